FILE: rtl/core/ukvt_pkg.sv
// Shared types for the unsorted key/value table: command codes and the
// request/response transfer structs. No dependencies.
`timescale 1ns / 1ps

package ukvt_pkg;

   // Command codes carried in the request
   typedef enum logic [2:0] {
      CMD_INSERT     = 3'd0,
      CMD_UPDATE     = 3'd1,
      CMD_INS_OR_UPD = 3'd2,
      CMD_ERASE      = 3'd3,
      CMD_CONTAINS   = 3'd4,
      CMD_GET_KEY    = 3'd5,
      CMD_GET_INDEX  = 3'd6
   } ukvt_cmd_type;

   // One request transfer
   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] lookup_key;
      logic [31:0] new_value;
      logic [3:0]  position;
   } ukvt_req_type;

   // One response transfer
   typedef struct packed {
      logic        ok;
      logic [31:0] read_key;
      logic [31:0] read_value;
      logic [4:0]  entry_count;
   } ukvt_rsp_type;

endpackage

FILE: rtl/core/ukvt_store.sv
// Key and value storage of the unsorted key/value table: one write port and
// one read port with registered read data. Depends on nothing else.
`timescale 1ns / 1ps

module ukvt_store #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32,
   parameter int ADDR_BITS   = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [KEY_BITS-1:0]   wr_key,
   input  logic [VALUE_BITS-1:0] wr_value,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [KEY_BITS-1:0]   rd_key,
   output logic [VALUE_BITS-1:0] rd_value
);

   logic [KEY_BITS-1:0]   key_mem   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_value_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
   end

   // registered read port, read every cycle
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

FILE: rtl/core/unsorted_key_value_table_core.sv
// Unsorted key/value table, top level: command sequencer, entry count and
// response register. Uses ukvt_pkg and ukvt_store.
//
// The table holds up to TABLE_DEPTH key/value pairs packed in positions
// 0..count-1. A request is taken only while the sequencer is idle; every
// request gives exactly one response, which waits in an output register so
// the next request can be taken while it is pending. Key commands scan the
// stored entries through the single registered read port, one entry per
// cycle, stopping at the first match. Insert appends an absent key when
// there is room, as does insert-or-update; on a hit, erase, update and
// insert-or-update move the last entry into the freed slot, and the two
// updates then append the new pair. Reading by position is a single read
// of the same port.
// Key and value fields are cut to KEY_BITS and VALUE_BITS on entry.
`timescale 1ns / 1ps

module unsorted_key_value_table_core #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ukvt_pkg::ukvt_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ukvt_pkg::ukvt_rsp_type rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_APPEND,
      ST_IDX_RD,
      ST_IDX_WAIT,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [3:0]             pos_ff, pos_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [AW-1:0]          rd_pos_ff, rd_pos_in;
   logic [AW-1:0]          at_ff, at_in;
   logic                   found_ff, found_in;
   logic                   ok_ff, ok_in;
   logic [31:0]            rkey_ff, rkey_in;
   logic [31:0]            rval_ff, rval_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ukvt_pkg::ukvt_rsp_type rsp_ff, rsp_in;

   // storage port signals
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_value;
   logic [AW-1:0]         rd_addr;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   // width adapters between fixed fields and parameterized storage
   logic [63:0]    key_req_wide, val_req_wide;
   logic [63:0]    key_m_wide, rd_key_wide, rd_value_wide;
   logic [KEY_BITS-1:0]   key_m;
   logic [VALUE_BITS-1:0] val_m;
   logic [AW+3:0]  pos_wide;
   logic [CW+3:0]  pos_cmp, count_cmp;
   logic [CW+4:0]  count_out_wide;
   logic [CW-1:0]  last_count;
   logic [AW-1:0]  last_addr;
   logic           hit, scan_more, has_room, pos_in_range;

   assign key_req_wide   = 64'(req_data.lookup_key);
   assign val_req_wide   = 64'(req_data.new_value);
   assign key_m          = key_req_wide[KEY_BITS-1:0];
   assign val_m          = val_req_wide[VALUE_BITS-1:0];
   assign key_m_wide     = 64'(key_m);
   assign rd_key_wide    = 64'(rd_key);
   assign rd_value_wide  = 64'(rd_value);
   assign pos_wide       = (AW + 4)'(pos_ff);
   assign pos_cmp        = (CW + 4)'(req_data.position);
   assign count_cmp      = (CW + 4)'(count_ff);
   assign count_out_wide = (CW + 5)'(count_ff);
   assign last_count     = count_ff - CW'(1);
   assign last_addr      = last_count[AW-1:0];

   assign hit          = rd_vld_ff && (rd_key == key_ff);
   assign scan_more    = issue_ff < count_ff;
   assign has_room     = count_ff < CW'(TABLE_DEPTH);
   assign pos_in_range = pos_cmp < count_cmp;

   ukvt_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS),
      .ADDR_BITS   (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_value (wr_value),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   // sequencer next state and memory control
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_pos_in    = rd_pos_ff;
      at_in        = at_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      rkey_in      = rkey_ff;
      rval_in      = rval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = at_ff;
      wr_key       = key_ff;
      wr_value     = val_ff;
      rd_addr      = '0;

      // response register drains on its transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_data.command;
               key_in   = key_m;
               val_in   = val_m;
               pos_in   = req_data.position;
               issue_in = '0;
               found_in = 1'b0;
               ok_in    = 1'b0;
               rkey_in  = key_m_wide[31:0];
               rval_in  = '0;
               case (req_data.command)
                  ukvt_pkg::CMD_INSERT, ukvt_pkg::CMD_UPDATE, ukvt_pkg::CMD_INS_OR_UPD,
                  ukvt_pkg::CMD_ERASE, ukvt_pkg::CMD_CONTAINS, ukvt_pkg::CMD_GET_KEY: begin
                     state_in = ST_SCAN;
                  end
                  ukvt_pkg::CMD_GET_INDEX: begin
                     state_in = pos_in_range ? ST_IDX_RD : ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // one read issued and one compare per cycle
         ST_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
               at_in    = rd_pos_ff;
               case (cmd_ff)
                  ukvt_pkg::CMD_UPDATE, ukvt_pkg::CMD_INS_OR_UPD, ukvt_pkg::CMD_ERASE: begin
                     ok_in    = 1'b1;
                     state_in = ST_MOVE_RD;
                  end
                  ukvt_pkg::CMD_CONTAINS: begin
                     ok_in    = 1'b1;
                     state_in = ST_FINISH;
                  end
                  ukvt_pkg::CMD_GET_KEY: begin
                     ok_in    = 1'b1;
                     rval_in  = rd_value_wide[31:0];
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end else if (scan_more) begin
               rd_addr   = issue_ff[AW-1:0];
               issue_in  = issue_ff + CW'(1);
               rd_vld_in = 1'b1;
               rd_pos_in = issue_ff[AW-1:0];
            end else begin
               // key absent
               found_in = 1'b0;
               case (cmd_ff)
                  ukvt_pkg::CMD_INSERT, ukvt_pkg::CMD_INS_OR_UPD: begin
                     ok_in    = has_room;
                     state_in = has_room ? ST_APPEND : ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_MOVE_RD: begin
            rd_addr  = last_addr;
            state_in = ST_MOVE_WR;
         end

         // last entry fills the freed slot
         ST_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = at_ff;
            wr_key   = rd_key;
            wr_value = rd_value;
            if (cmd_ff == ukvt_pkg::CMD_ERASE) begin
               count_in = last_count;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_APPEND;
            end
         end

         // new pair goes last; update reuses the slot the erase freed
         ST_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = found_ff ? last_addr : count_ff[AW-1:0];
            if (!found_ff) begin
               count_in = count_ff + CW'(1);
            end
            state_in = ST_FINISH;
         end

         ST_IDX_RD: begin
            rd_addr  = pos_wide[AW-1:0];
            state_in = ST_IDX_WAIT;
         end

         ST_IDX_WAIT: begin
            ok_in    = 1'b1;
            rkey_in  = rd_key_wide[31:0];
            rval_in  = rd_value_wide[31:0];
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.ok          = ok_ff;
               rsp_in.read_key    = rkey_ff;
               rsp_in.read_value  = rval_ff;
               rsp_in.entry_count = count_out_wide[4:0];
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      issue_ff  <= issue_in;
      rd_pos_ff <= rd_pos_in;
      at_ff     <= at_in;
      found_ff  <= found_in;
      ok_ff     <= ok_in;
      rkey_ff   <= rkey_in;
      rval_ff   <= rval_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/ukvt_checker.sv
// Port-level checks for the unsorted key/value table and the bind that
// attaches them to the top level. Uses ukvt_pkg.
`timescale 1ns / 1ps

module ukvt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input ukvt_pkg::ukvt_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ukvt_pkg::ukvt_rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one command at a time: a request transfer closes the input side
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in progress");

   // a failed command reads no value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.read_value == 32'd0)
      else $error("failed command returned a value");

   // reset leaves the block idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind unsorted_key_value_table_core ukvt_checker u_ukvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: sim/tb_unsorted_key_value_table_core.sv
// Self-checking testbench for unsorted_key_value_table_core: a class-based mirror of the
// table predicts each response, and random traffic with random stalls runs on both ports.
// Depends on ukvt_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module tb_unsorted_key_value_table_core;

   localparam int DEPTH        = 16;
   localparam int CLK_HALF     = 5;
   localparam int LONG_HOLD    = 300;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 125;
   localparam int POOL_SIZE    = 20;
   localparam int DRAIN_CYCLES = 40;
   // Command code outside the defined set; the core must ignore it
   localparam logic [2:0] CMD_RESERVED = 3'd7;

   typedef enum {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_kind_type;

   // Mirror of the table contents; predicts one response per accepted request
   class table_mirror;
      logic [31:0]  key_tbl [DEPTH];
      logic [31:0]  val_tbl [DEPTH];
      int unsigned  held = 0;
      int unsigned  errors = 0;
      ukvt_pkg::ukvt_rsp_type awaited_replies [$];

      function int find_slot(logic [31:0] key);
         for (int i = 0; i < held; i++)
            if (key_tbl[i] == key) return i;
         return -1;
      endfunction

      function bit append_pair(logic [31:0] key, logic [31:0] value);
         if (find_slot(key) >= 0 || held >= DEPTH) return 1'b0;
         key_tbl[held] = key;
         val_tbl[held] = value;
         held++;
         return 1'b1;
      endfunction

      // Last entry moves into the freed slot
      function bit remove_key(logic [31:0] key);
         int at;
         at = find_slot(key);
         if (at < 0) return 1'b0;
         key_tbl[at] = key_tbl[held - 1];
         val_tbl[at] = val_tbl[held - 1];
         held--;
         return 1'b1;
      endfunction

      function int outstanding();
         return awaited_replies.size();
      endfunction

      function void note_request(ukvt_pkg::ukvt_req_type req);
         ukvt_pkg::ukvt_rsp_type rsp;
         int at;
         rsp.ok         = 1'b0;
         rsp.read_key   = req.lookup_key;
         rsp.read_value = '0;
         case (req.command)
            ukvt_pkg::CMD_INSERT: rsp.ok = append_pair(req.lookup_key, req.new_value);
            ukvt_pkg::CMD_UPDATE: begin
               // update = erase then append, so the pair ends up last
               rsp.ok = remove_key(req.lookup_key);
               if (rsp.ok) void'(append_pair(req.lookup_key, req.new_value));
            end
            ukvt_pkg::CMD_INS_OR_UPD: begin
               if (find_slot(req.lookup_key) >= 0) begin
                  void'(remove_key(req.lookup_key));
                  void'(append_pair(req.lookup_key, req.new_value));
                  rsp.ok = 1'b1;
               end else begin
                  rsp.ok = append_pair(req.lookup_key, req.new_value);
               end
            end
            ukvt_pkg::CMD_ERASE:    rsp.ok = remove_key(req.lookup_key);
            ukvt_pkg::CMD_CONTAINS: rsp.ok = (find_slot(req.lookup_key) >= 0);
            ukvt_pkg::CMD_GET_KEY: begin
               at = find_slot(req.lookup_key);
               if (at >= 0) begin
                  rsp.ok         = 1'b1;
                  rsp.read_value = val_tbl[at];
               end
            end
            ukvt_pkg::CMD_GET_INDEX: begin
               if (req.position < held) begin
                  rsp.ok         = 1'b1;
                  rsp.read_key   = key_tbl[req.position];
                  rsp.read_value = val_tbl[req.position];
               end
            end
            default: ;
         endcase
         rsp.entry_count = 5'(held);
         awaited_replies.push_back(rsp);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_reply(ukvt_pkg::ukvt_rsp_type got);
         ukvt_pkg::ukvt_rsp_type want;
         if (awaited_replies.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = awaited_replies.pop_front();
         compare_field("ok", 32'(want.ok), 32'(got.ok));
         compare_field("read_key", want.read_key, got.read_key);
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_ready;
   ukvt_pkg::ukvt_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   ukvt_pkg::ukvt_rsp_type rsp_data;

   bit           steady   = 1'b0;  // no idling on either side
   bit           hold_rsp = 1'b0;  // request for one long receiver hold-off
   table_mirror  mirror;
   logic [31:0]  key_pool [POOL_SIZE];
   logic [31:0]  fill_keys [DEPTH];

   unsorted_key_value_table_core #(
      .TABLE_DEPTH(DEPTH),
      .KEY_BITS(32),
      .VALUE_BITS(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #CLK_HALF clock = ~clock;

   // Mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [2:0] pick_command(mix_kind_type mix);
      int unsigned roll;
      int unsigned put_pct;
      int unsigned upd_pct;
      int unsigned del_pct;
      int unsigned pick;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:  begin put_pct = 55; upd_pct = 8;  del_pct = 7;  end
         MIX_CHURN: begin put_pct = 28; upd_pct = 12; del_pct = 18; end
         default:   begin put_pct = 12; upd_pct = 6;  del_pct = 40; end
      endcase
      if (roll < put_pct)
         return ($urandom_range(0, 2) == 0) ? ukvt_pkg::CMD_INS_OR_UPD : ukvt_pkg::CMD_INSERT;
      roll -= put_pct;
      if (roll < upd_pct) return ukvt_pkg::CMD_UPDATE;
      roll -= upd_pct;
      if (roll < del_pct) return ukvt_pkg::CMD_ERASE;
      // remaining share goes to lookups, with a rare reserved code
      pick = $urandom_range(0, 19);
      if (pick == 0) return CMD_RESERVED;
      if (pick < 6)  return ukvt_pkg::CMD_CONTAINS;
      if (pick < 12) return ukvt_pkg::CMD_GET_KEY;
      return ukvt_pkg::CMD_GET_INDEX;
   endfunction

   // Keys mostly from a small pool so hits, duplicates and a full table occur
   function automatic ukvt_pkg::ukvt_req_type make_item(mix_kind_type mix);
      ukvt_pkg::ukvt_req_type req;
      req.command    = pick_command(mix);
      req.lookup_key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                     : $urandom;
      req.new_value  = $urandom;
      req.position   = 4'($urandom_range(0, 15));
      return req;
   endfunction

   // Raise valid at the falling edge and hold until the transfer happens
   task automatic send_item(input ukvt_pkg::ukvt_req_type req);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic issue(input logic [2:0] cmd, input logic [31:0] key,
                        input logic [31:0] value, input logic [3:0] pos);
      ukvt_pkg::ukvt_req_type req;
      req.command    = cmd;
      req.lookup_key = key;
      req.new_value  = value;
      req.position   = pos;
      send_item(req);
      pause_sender(pick_gap());
   endtask

   // Drop valid and wait for every awaited response
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
   endtask

   // Sample both channels at the rising edge; responses first, they belong to older requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) mirror.check_reply(rsp_data);
         if (req_valid && req_ready) mirror.note_request(req_data);
      end
   end

   // Response side: random stalls, one long hold-off on request
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp  = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // Watchdog: ~1300 items, with the time limit set several times over what they need
   initial begin
      #8_000_000;
      $display("tb_unsorted_key_value_table_core NOT OK");
      $finish;
   end

   initial begin
      mirror    = new;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: misses and out-of-range position
      issue(ukvt_pkg::CMD_GET_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd0);
      issue(ukvt_pkg::CMD_ERASE,     32'h0000_1234, 32'h0000_0000, 4'd0);
      issue(ukvt_pkg::CMD_UPDATE,    32'h0000_1234, 32'hdead_beef, 4'd0);
      issue(ukvt_pkg::CMD_GET_KEY,   32'h0000_1234, 32'h0000_0000, 4'd0);
      issue(ukvt_pkg::CMD_CONTAINS,  32'h0000_0000, 32'h0000_0000, 4'd0);
      // Extreme keys and values, duplicate insert
      issue(ukvt_pkg::CMD_INSERT,    32'h0000_0000, 32'hffff_ffff, 4'd15);
      issue(ukvt_pkg::CMD_INSERT,    32'hffff_ffff, 32'h0000_0000, 4'd0);
      issue(ukvt_pkg::CMD_INSERT,    32'h0000_0000, 32'h0000_0005, 4'd0);
      issue(ukvt_pkg::CMD_GET_KEY,   32'hffff_ffff, 32'h0000_0000, 4'd0);
      issue(ukvt_pkg::CMD_GET_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd1);
      issue(ukvt_pkg::CMD_GET_INDEX, 32'h1111_1111, 32'h0000_0000, 4'd15);
      issue(ukvt_pkg::CMD_CONTAINS,  32'h0000_0000, 32'h0000_0000, 4'd0);
      // Update moves the pair to the last slot
      issue(ukvt_pkg::CMD_UPDATE,    32'h0000_0000, 32'haaaa_aaaa, 4'd0);
      issue(ukvt_pkg::CMD_GET_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd1);
      issue(ukvt_pkg::CMD_INS_OR_UPD, 32'hffff_ffff, 32'h5555_5555, 4'd0);
      issue(ukvt_pkg::CMD_INS_OR_UPD, 32'h1234_5678, 32'h8765_4321, 4'd0);
      issue(ukvt_pkg::CMD_GET_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd0);
      // Erase from the middle, reserved code, erase from the front
      issue(ukvt_pkg::CMD_ERASE,     32'hffff_ffff, 32'h0000_0000, 4'd0);
      issue(CMD_RESERVED,            32'hcafe_f00d, 32'h1234_5678, 4'd7);
      issue(ukvt_pkg::CMD_ERASE,     32'h0000_0000, 32'h0000_0000, 4'd0);
      issue(ukvt_pkg::CMD_GET_INDEX, 32'h0000_0000, 32'h0000_0000, 4'd0);

      // Fill to capacity, then hit the full-table cases
      for (int i = 0; i < DEPTH; i++) begin
         fill_keys[i] = $urandom;
         issue(ukvt_pkg::CMD_INSERT, fill_keys[i], $urandom, 4'($urandom_range(0, 15)));
      end
      issue(ukvt_pkg::CMD_INSERT,     $urandom, $urandom, 4'd0);
      issue(ukvt_pkg::CMD_INS_OR_UPD, $urandom, $urandom, 4'd0);
      issue(ukvt_pkg::CMD_INS_OR_UPD, fill_keys[3], $urandom, 4'd0);
      issue(ukvt_pkg::CMD_GET_INDEX,  32'h0000_0000, 32'h0000_0000, 4'd15);
      for (int i = DEPTH - 1; i >= 0; i--)
         issue(ukvt_pkg::CMD_ERASE, fill_keys[i], 32'h0000_0000, 4'd0);
      // Sender waits for every response before going on
      wait_drained();

      // Random phases cycling between growing, churning and shrinking the table
      for (int ph = 0; ph < PHASES; ph++) begin
         foreach (key_pool[k]) key_pool[k] = $urandom;
         steady = (ph == 4 || ph == 7);
         // one long receiver hold-off while requests keep coming
         if (ph == 2) hold_rsp = 1'b1;
         repeat (PHASE_ITEMS) begin
            send_item(make_item(mix_kind_type'(ph % 3)));
            pause_sender(pick_gap());
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.errors == 0 && mirror.outstanding() == 0) begin
         $display("tb_unsorted_key_value_table_core OK");
      end else begin
         $display("tb_unsorted_key_value_table_core NOT OK");
      end
      $finish;
   end

endmodule
